// ===== src/jbe_pkg.sv =====
package jbe_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int MAX_COLUMNS_DEF = 12;
    localparam int LOG_FRAC        = 40;
    localparam int ENTROPY_W       = 20;
    localparam int CFG_W           = 11;

    typedef enum logic [1:0] {
        FUNC_RESTART = 2'd0,
        FUNC_COLUMN  = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_EXTRA   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_TOO_MANY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_BAD,
        RES_COL,
        RES_OK_ZERO,
        RES_QUOT
    } res_sel_t;

    typedef enum logic [4:0] {
        S_CLR_ALL,
        S_CLR_HIST,
        S_IDLE,
        S_Q_RD,
        S_Q_HR,
        S_Q_WR,
        S_B_RD,
        S_B_MOD,
        S_B_HW,
        S_B_END,
        S_D_RD,
        S_D_RM,
        S_D_AC,
        S_D_FIN,
        S_D_CMP,
        S_DIV,
        S_RES,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0] func;
        logic       bit_req;
        logic       last;
    } request_t;

    typedef struct packed {
        logic [ENTROPY_W-1:0] entropy;
        logic [1:0]           status;
    } result_t;

    typedef struct packed {
        logic     accept;
        logic     clr_ctx;
        logic     idx_zero;
        logic     idx_inc;
        logic     clr_codes;
        logic     clr_hist;
        logic     code_rd_idx;
        logic     code_rd_pos;
        logic     codes_shift;
        logic     hist_rd_code;
        logic     hist_rd_ext;
        logic     hist_rd_idx;
        logic     hist_inc;
        logic     hist_zero;
        logic     step_end;
        logic     col_end;
        logic     rom_cnt;
        logic     rom_total;
        logic     sum_clear;
        logic     sum_acc;
        logic     div_load;
        logic     div_step;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic q_bad;
        logic pos_lt_n;
        logic col_full;
        logic last;
        logic bad_end;
        logic idx_n_last;
        logic idx_h_last;
        logic walk_last;
        logic sum_ge;
        logic div_last;
    } dp_stat_t;

    // c*log2(c) with 16 fraction bits, log2 by repeated squaring
    function automatic logic [63:0] xlogx(input int c);
        logic [63:0]  x;
        logic [63:0]  l;
        logic [127:0] sq;
        int           k;
        k  = 0;
        x  = 64'd0;
        l  = 64'd0;
        sq = 128'd0;
        if (c < 2)
        begin
            return 64'd0;
        end
        for (int j = 1; j < 31; j++)
        begin
            if ((c >> j) != 0)
            begin
                k = j;
            end
        end
        x = 64'(c) << (62 - k);
        l = 64'(k) << LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--)
        begin
            sq = 128'(x) * 128'(x);
            x  = sq[125:62];
            if (x[63])
            begin
                x    = x >> 1;
                l[i] = 1'b1;
            end
        end
        return (64'(c) * l + (64'd1 << 23)) >> 24;
    endfunction

endpackage

// ===== src/jbe_ram.sv =====
module jbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/jbe_ctrl.sv =====
module jbe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  jbe_pkg::dp_stat_t stat,
    output jbe_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import jbe_pkg::*;

    state_t state_reg, state_next;
    func_t  func_reg, func_next;
    logic   acc;
    func_t  func_in;

    assign func_in = func_t'(func);
    assign acc     = start && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_ALL;
            func_reg  <= FUNC_RESTART;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
        end
    end

    always_comb
    begin
        func_next = acc ? func_in : func_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_ALL:  if (stat.walk_last) state_next = S_IDLE;
            S_CLR_HIST: if (stat.walk_last) state_next = S_OUT;
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (func_in)
                        FUNC_RESTART: state_next = S_CLR_ALL;
                        FUNC_QUERY:   state_next = stat.q_bad ? S_OUT : S_Q_RD;
                        FUNC_COLUMN:
                            state_next = (stat.pos_lt_n && !stat.col_full) ? S_B_RD : S_B_END;
                        FUNC_EXTRA:   state_next = stat.pos_lt_n ? S_B_RD : S_B_END;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_Q_RD:     state_next = S_Q_HR;
            S_Q_HR:     state_next = S_Q_WR;
            S_Q_WR:     state_next = stat.idx_n_last ? S_D_RD : S_Q_RD;
            S_B_RD:     state_next = S_B_MOD;
            S_B_MOD:    state_next = (func_reg == FUNC_EXTRA) ? S_B_HW : S_B_END;
            S_B_HW:     state_next = S_B_END;
            S_B_END:
            begin
                if (!stat.last)
                    state_next = S_IDLE;
                else if (func_reg == FUNC_COLUMN)
                    state_next = S_OUT;
                else if (stat.bad_end)
                    state_next = S_CLR_HIST;
                else
                    state_next = S_D_RD;
            end
            S_D_RD:     state_next = S_D_RM;
            S_D_RM:     state_next = S_D_AC;
            S_D_AC:     state_next = stat.idx_h_last ? S_D_FIN : S_D_RD;
            S_D_FIN:    state_next = S_D_CMP;
            S_D_CMP:    state_next = stat.sum_ge ? S_OUT : S_DIV;
            S_DIV:      state_next = stat.div_last ? S_RES : S_DIV;
            S_RES:      state_next = S_OUT;
            S_OUT:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd     = '0;
        cmd.res_sel = RES_NONE;
        busy    = (state_reg != S_IDLE);
        done    = (state_reg == S_OUT);
        unique case (state_reg)
            S_CLR_ALL:
            begin
                cmd.clr_codes = 1'b1;
                cmd.clr_hist  = 1'b1;
                cmd.idx_inc   = 1'b1;
            end
            S_CLR_HIST:
            begin
                cmd.clr_hist = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.accept    = 1'b1;
                    cmd.idx_zero  = 1'b1;
                    cmd.sum_clear = 1'b1;
                    if (func_in == FUNC_RESTART)
                        cmd.clr_ctx = 1'b1;
                    if (func_in == FUNC_QUERY && stat.q_bad)
                        cmd.res_sel = RES_BAD;
                end
            end
            S_Q_RD:  cmd.code_rd_idx = 1'b1;
            S_Q_HR:  cmd.hist_rd_code = 1'b1;
            S_Q_WR:
            begin
                cmd.hist_inc = 1'b1;
                if (stat.idx_n_last)
                    cmd.idx_zero = 1'b1;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_B_RD:  cmd.code_rd_pos = 1'b1;
            S_B_MOD:
            begin
                if (func_reg == FUNC_EXTRA)
                    cmd.hist_rd_ext = 1'b1;
                else
                    cmd.codes_shift = 1'b1;
            end
            S_B_HW:  cmd.hist_inc = 1'b1;
            S_B_END:
            begin
                cmd.step_end = 1'b1;
                cmd.idx_zero = 1'b1;
                if (stat.last)
                begin
                    if (func_reg == FUNC_COLUMN)
                    begin
                        cmd.col_end = 1'b1;
                        cmd.res_sel = RES_COL;
                    end
                    else if (stat.bad_end)
                        cmd.res_sel = RES_BAD;
                end
            end
            S_D_RD:  cmd.hist_rd_idx = 1'b1;
            S_D_RM:
            begin
                cmd.hist_zero = 1'b1;
                cmd.rom_cnt   = 1'b1;
            end
            S_D_AC:
            begin
                cmd.sum_acc = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_D_FIN: cmd.rom_total = 1'b1;
            S_D_CMP:
            begin
                if (stat.sum_ge)
                    cmd.res_sel = RES_OK_ZERO;
                else
                    cmd.div_load = 1'b1;
            end
            S_DIV:   cmd.div_step = 1'b1;
            S_RES:   cmd.res_sel = RES_QUOT;
            S_OUT:   cmd.res_sel = RES_NONE;
            default: cmd.res_sel = RES_NONE;
        endcase
    end

endmodule

// ===== src/jbe_dp.sv =====
module jbe_dp #(
    parameter int MAX_SAMPLES = jbe_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_COLUMNS = jbe_pkg::MAX_COLUMNS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  jbe_pkg::dp_cmd_t           cmd,
    input  jbe_pkg::request_t          request,
    input  logic [jbe_pkg::CFG_W-1:0]  sample_count,
    output jbe_pkg::dp_stat_t          stat,
    output jbe_pkg::result_t           result
);
    import jbe_pkg::*;

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int HAW  = MAX_COLUMNS + 1;
    localparam int HD   = 1 << HAW;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int PW   = $clog2(MAX_SAMPLES + 2);
    localparam int WALK = (HD > MAX_SAMPLES) ? HD : MAX_SAMPLES;
    localparam int IW   = $clog2(WALK);
    localparam int TW   = CW + 21;
    // every histogram entry may sit at the count cap
    localparam int SW   = TW + HAW;
    localparam int DW   = $clog2(TW);
    localparam int COLW = $clog2(MAX_COLUMNS + 1);

    logic [CW-1:0]          n;
    logic                   bit_reg, last_reg;
    logic [PW-1:0]          pos_reg, pos_inc;
    logic [COLW-1:0]        col_reg;
    logic                   lenerr_reg;
    logic [IW-1:0]          idx_reg;
    logic                   bad_len, col_full;

    logic                   codes_we;
    logic [AW-1:0]          codes_waddr, codes_raddr;
    logic [MAX_COLUMNS-1:0] codes_wdata, codes_rdata;
    logic                   hist_we;
    logic [HAW-1:0]         hist_waddr, hist_raddr, hist_addr_reg;
    logic [CW-1:0]          hist_wdata, hist_rdata, hist_cap;

    logic [TW-1:0]          rom_tab [MAX_SAMPLES + 1];
    logic [CW-1:0]          rom_idx;
    logic [TW-1:0]          rom_reg;
    logic [SW-1:0]          sum_reg;
    logic [TW-1:0]          dq_reg;
    logic [CW-1:0]          rem_reg;
    logic [DW-1:0]          divcnt_reg;
    logic [CW:0]            div_sh;
    logic                   div_ge;
    logic [ENTROPY_W-1:0]   entropy_reg, quot_sat;
    logic [1:0]             status_reg, col_status;

    // effective sample count
    always_comb
    begin
        if (sample_count == '0)
            n = CW'(1);
        else if (32'(sample_count) > MAX_SAMPLES)
            n = CW'(MAX_SAMPLES);
        else
            n = CW'(sample_count);
    end

    assign pos_inc  = (32'(pos_reg) <= MAX_SAMPLES) ? pos_reg + PW'(1) : pos_reg;
    assign bad_len  = (pos_inc != PW'(n));
    assign col_full = (32'(col_reg) == MAX_COLUMNS);

    always_comb
    begin
        if (col_full)
            col_status = STATUS_TOO_MANY;
        else if (bad_len)
            col_status = STATUS_LENGTH;
        else
            col_status = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            col_reg    <= '0;
            lenerr_reg <= 1'b0;
            idx_reg    <= '0;
            divcnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr_ctx)
            begin
                pos_reg    <= '0;
                col_reg    <= '0;
                lenerr_reg <= 1'b0;
            end
            if (cmd.step_end)
            begin
                pos_reg <= last_reg ? '0 : pos_inc;
                if (cmd.col_end && !col_full)
                begin
                    col_reg <= col_reg + COLW'(1);
                    if (bad_len)
                        lenerr_reg <= 1'b1;
                end
            end
            if (cmd.idx_zero)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.div_load)
                divcnt_reg <= '0;
            else if (cmd.div_step)
                divcnt_reg <= divcnt_reg + DW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bit_reg  <= request.bit_req;
            last_reg <= request.last;
        end
    end

    // sample code store
    assign codes_raddr = cmd.code_rd_idx ? idx_reg[AW-1:0] : pos_reg[AW-1:0];
    always_comb
    begin
        codes_we    = 1'b0;
        codes_waddr = idx_reg[AW-1:0];
        codes_wdata = '0;
        if (cmd.clr_codes)
            codes_we = (32'(idx_reg) < MAX_SAMPLES);
        else if (cmd.codes_shift)
        begin
            codes_we    = 1'b1;
            codes_waddr = pos_reg[AW-1:0];
            codes_wdata = MAX_COLUMNS'({codes_rdata, bit_reg});
        end
    end

    jbe_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_SAMPLES)
    ) u_codes (
        .clk   (clk),
        .we    (codes_we),
        .waddr (codes_waddr),
        .wdata (codes_wdata),
        .raddr (codes_raddr),
        .rdata (codes_rdata)
    );

    // histogram
    always_comb
    begin
        if (cmd.hist_rd_code)
            hist_raddr = HAW'(codes_rdata);
        else if (cmd.hist_rd_ext)
            hist_raddr = {codes_rdata, bit_reg};
        else
            hist_raddr = idx_reg[HAW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd_code || cmd.hist_rd_ext || cmd.hist_rd_idx)
            hist_addr_reg <= hist_raddr;
    end

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = idx_reg[HAW-1:0];
        hist_wdata = '0;
        if (cmd.clr_hist)
            hist_we = (32'(idx_reg) < HD);
        else if (cmd.hist_zero)
            hist_we = 1'b1;
        else if (cmd.hist_inc)
        begin
            hist_we    = 1'b1;
            hist_waddr = hist_addr_reg;
            hist_wdata = (32'(hist_rdata) < MAX_SAMPLES) ? hist_rdata + CW'(1) : hist_rdata;
        end
    end

    jbe_ram #(
        .WIDTH (CW),
        .DEPTH (HD)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // c*log2(c) table
    for (genvar c = 0; c <= MAX_SAMPLES; c++)
    begin : g_rom
        localparam logic [63:0] TV = xlogx(c);
        assign rom_tab[c] = TV[TW-1:0];
    end

    assign hist_cap = (32'(hist_rdata) > MAX_SAMPLES) ? CW'(MAX_SAMPLES) : hist_rdata;
    assign rom_idx  = cmd.rom_total ? n : hist_cap;

    always_ff @(posedge clk)
    begin
        if (cmd.rom_cnt || cmd.rom_total)
            rom_reg <= rom_tab[rom_idx];
        if (cmd.sum_clear)
            sum_reg <= '0;
        else if (cmd.sum_acc)
            sum_reg <= sum_reg + SW'(rom_reg);
    end

    // restoring divider, one quotient bit a cycle
    assign div_sh = {rem_reg, dq_reg[TW-1]};
    assign div_ge = (div_sh >= {1'b0, n});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dq_reg  <= rom_reg - sum_reg[TW-1:0];
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? CW'(div_sh - {1'b0, n}) : div_sh[CW-1:0];
            dq_reg  <= {dq_reg[TW-2:0], div_ge};
        end
    end

    assign quot_sat = (|dq_reg[TW-1:ENTROPY_W]) ? '1 : dq_reg[ENTROPY_W-1:0];

    always_ff @(posedge clk)
    begin
        case (cmd.res_sel)
            RES_BAD:
            begin
                entropy_reg <= '0;
                status_reg  <= STATUS_LENGTH;
            end
            RES_COL:
            begin
                entropy_reg <= '0;
                status_reg  <= col_status;
            end
            RES_OK_ZERO:
            begin
                entropy_reg <= '0;
                status_reg  <= STATUS_OK;
            end
            RES_QUOT:
            begin
                entropy_reg <= quot_sat;
                status_reg  <= STATUS_OK;
            end
            default:
            begin
                entropy_reg <= entropy_reg;
                status_reg  <= status_reg;
            end
        endcase
    end

    assign result.entropy = entropy_reg;
    assign result.status  = status_reg;

    assign stat.q_bad      = (pos_reg != '0) || lenerr_reg;
    assign stat.pos_lt_n   = (pos_reg < PW'(n));
    assign stat.col_full   = col_full;
    assign stat.last       = last_reg;
    assign stat.bad_end    = bad_len || lenerr_reg;
    assign stat.idx_n_last = (32'(idx_reg) == 32'(n) - 32'd1);
    assign stat.idx_h_last = (32'(idx_reg) == HD - 1);
    assign stat.walk_last  = (32'(idx_reg) == WALK - 1);
    assign stat.sum_ge     = (sum_reg >= SW'(rom_reg));
    assign stat.div_last   = (32'(divcnt_reg) == TW - 1);

endmodule

// ===== src/joint_binary_entropy.sv =====
// joint binary entropy of binary feature columns
// command channel: an item (request) is taken at a clock edge with start high
// and busy low. func restart clears all state, add-column bits shift one
// sample's feature into its stored code, a query returns the entropy of the
// code distribution, and extra-column bits count code*2+bit without storing.
// a result sits on result for one cycle with done high; it cannot be held off.
// apb port: register sample_count at byte address 0. the user must write it
// only while idle; the block itself does not enforce this. from one accepted
// item to the next: a stored column bit reads its code, shifts the bit in and
// writes it back; an extra-column bit reads the code and bumps its histogram
// entry; a bit past the column end or past a full code word only ends the step.
// a column's last bit adds a result. a query reads each sample's code and bumps
// its histogram entry, then walks the histogram, reading and clearing every
// entry, then runs a bit-serial divide by n; a refused query only gives its
// result. an extra column's last bit adds the same walk and divide. restart and
// reset run a clearing pass over the code and histogram stores with busy high.
module joint_binary_entropy #(
    parameter int MAX_SAMPLES = jbe_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_COLUMNS = jbe_pkg::MAX_COLUMNS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  jbe_pkg::request_t request,
    output logic              done,
    output jbe_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import jbe_pkg::*;

    logic [CFG_W-1:0] sample_count_reg;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_count_reg <= CFG_W'(1024);
        else if (psel && penable && pwrite && !paddr[2])
            sample_count_reg <= pwdata[CFG_W-1:0];
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(sample_count_reg);

    jbe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (request.func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    jbe_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .request      (request),
        .sample_count (sample_count_reg),
        .stat         (stat),
        .result       (result)
    );

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after a result");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func == FUNC_RESTART) |=> busy)
        else $error("restart did not start the clearing pass");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STATUS_OK) |-> (result.entropy == '0))
        else $error("flagged result carries an entropy");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !cmd.accept)
        else $error("item taken while a result is shown");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import jbe_pkg::*;

    localparam int N_MAX      = 1024;
    localparam int COLS       = 12;
    localparam int HIST_SIZE  = 1 << (COLS + 1);
    localparam int CYCLE_CAP  = 5000000;
    localparam int HEAVY_CAP  = 20;

    class entropy_scoreboard;
        longint unsigned xlogx_tab[N_MAX + 1];
        bit [COLS-1:0]   codes[N_MAX];
        int unsigned     hist[HIST_SIZE];
        int unsigned     col_cnt;
        int unsigned     bit_pos;
        bit              len_err;
        bit [CFG_W-1:0]  sample_count;
        result_t         pending_results[$];
        int              errors;

        function new();
            longint unsigned x;
            longint unsigned l;
            bit [127:0]      p;
            int              k;
            for (int c = 0; c <= N_MAX; c++)
            begin
                xlogx_tab[c] = 0;
                if (c >= 2)
                begin
                    k = 0;
                    while ((c >> (k + 1)) != 0)
                    begin
                        k++;
                    end
                    x = longint'(c) << (62 - k);
                    l = longint'(k) << LOG_FRAC;
                    for (int i = LOG_FRAC - 1; i >= 0; i--)
                    begin
                        p = 128'(x) * 128'(x);
                        x = p[125:62];
                        if (x[63])
                        begin
                            x    = x >> 1;
                            l[i] = 1'b1;
                        end
                    end
                    xlogx_tab[c] = (longint'(c) * l + (64'd1 << 23)) >> 24;
                end
            end
            clear_state();
            sample_count = 11'd1024;
            errors = 0;
        endfunction

        function void clear_state();
            foreach (codes[i]) codes[i] = '0;
            foreach (hist[i]) hist[i] = 0;
            col_cnt = 0;
            bit_pos = 0;
            len_err = 0;
        endfunction

        function int unsigned eff_n();
            if (sample_count == 0) return 1;
            if (sample_count > N_MAX) return N_MAX;
            return sample_count;
        endfunction

        // reads and clears the histogram
        function logic [ENTROPY_W-1:0] drain_entropy(int unsigned n);
            longint unsigned sum;
            longint unsigned h;
            int unsigned     cnt;
            sum = 0;
            foreach (hist[i])
            begin
                cnt = (hist[i] > N_MAX) ? N_MAX : hist[i];
                sum += xlogx_tab[cnt];
                hist[i] = 0;
            end
            if (sum >= xlogx_tab[n]) return '0;
            h = (xlogx_tab[n] - sum) / n;
            return (h > 64'hFFFFF) ? 20'hFFFFF : h[ENTROPY_W-1:0];
        endfunction

        function void note_request(request_t r);
            int unsigned n;
            int unsigned code;
            bit          bad_len;
            result_t     res;
            n = eff_n();
            res.entropy = '0;
            res.status  = STATUS_OK;
            if (r.func == FUNC_RESTART)
            begin
                clear_state();
                return;
            end
            if (r.func == FUNC_QUERY)
            begin
                if (bit_pos != 0 || len_err)
                begin
                    res.status = STATUS_LENGTH;
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        hist[codes[i]]++;
                    end
                    res.entropy = drain_entropy(n);
                end
                pending_results.push_back(res);
                return;
            end
            if (bit_pos < n)
            begin
                if (r.func == FUNC_COLUMN)
                begin
                    if (col_cnt < COLS)
                    begin
                        codes[bit_pos] = {codes[bit_pos][COLS-2:0], r.bit_req};
                    end
                end
                else
                begin
                    code = {codes[bit_pos], r.bit_req};
                    if (hist[code] < N_MAX) hist[code]++;
                end
            end
            if (bit_pos <= N_MAX) bit_pos++;
            if (!r.last) return;
            bad_len = (bit_pos != n);
            bit_pos = 0;
            if (r.func == FUNC_COLUMN)
            begin
                if (col_cnt >= COLS)
                begin
                    res.status = STATUS_TOO_MANY;
                end
                else
                begin
                    col_cnt++;
                    if (bad_len)
                    begin
                        len_err = 1;
                        res.status = STATUS_LENGTH;
                    end
                end
            end
            else if (bad_len || len_err)
            begin
                foreach (hist[i]) hist[i] = 0;
                res.status = STATUS_LENGTH;
            end
            else
            begin
                res.entropy = drain_entropy(n);
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(result_t r);
            result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result entropy=%0d status=%0d", $time,
                         r.entropy, r.status);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (r.entropy !== exp_r.entropy)
            begin
                $display("%0t: entropy mismatch expected=%0d actual=%0d", $time,
                         exp_r.entropy, r.entropy);
                errors++;
            end
            if (r.status !== exp_r.status)
            begin
                $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                         exp_r.status, r.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    entropy_scoreboard sb = new();
    int  cycles;
    int  items_sent;
    int  heavy_ops;
    bit  no_idle;

    joint_binary_entropy u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(func_t f, bit b, bit l);
        request_t r;
        int       gap;
        r.func    = f;
        r.bit_req = b;
        r.last    = l;
        start   <= 1'b1;
        request <= r;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_request(r);
        items_sent++;
        if (f == FUNC_QUERY || (f == FUNC_EXTRA && l)) heavy_ops++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mix: percentage of extra-column bits inside an add-column column
    task automatic column(func_t f, int len, int mix);
        func_t g;
        for (int i = 1; i <= len; i++)
        begin
            g = f;
            if (mix > 0 && $urandom_range(0, 99) < mix) g = FUNC_EXTRA;
            send(g, $urandom_range(0, 1), i == len);
        end
    endtask

    // wait until the block is idle with nothing outstanding
    task automatic settle();
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_count(logic [10:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {21'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.sample_count = value;
    endtask

    task automatic new_setup(logic [10:0] value);
        settle();
        write_count(value);
        send(FUNC_RESTART, 0, 0);
    endtask

    initial
    begin
        int n;
        int ncols;
        int len;
        int r;
        cycles     = 0;
        items_sent = 0;
        heavy_ops  = 0;
        no_idle    = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small columns, queries, bad lengths, extra column
        new_setup(11'd4);
        column(FUNC_COLUMN, 4, 0);
        column(FUNC_COLUMN, 4, 0);
        send(FUNC_QUERY, 0, 0);
        column(FUNC_EXTRA, 4, 0);
        send(FUNC_COLUMN, 1, 0);
        send(FUNC_QUERY, 1, 1);
        send(FUNC_COLUMN, 0, 1);
        column(FUNC_COLUMN, 3, 0);
        send(FUNC_QUERY, 0, 0);
        column(FUNC_EXTRA, 4, 0);
        // too many columns at one sample, sample count 0 acts as 1
        new_setup(11'd0);
        for (int i = 0; i < COLS + 2; i++)
        begin
            send(FUNC_COLUMN, 1, 1);
        end
        send(FUNC_QUERY, 0, 0);
        // overlong column saturates the position
        new_setup(11'd2);
        column(FUNC_COLUMN, N_MAX + 6, 0);
        // full size via an oversized register value
        new_setup(11'd2047);
        send(FUNC_QUERY, 0, 0);

        // random phases
        while (items_sent < 1800)
        begin
            r = $urandom_range(0, 9);
            n = (r == 0) ? 1 : (r == 1) ? $urandom_range(17, 64) : $urandom_range(2, 16);
            no_idle = ($urandom_range(0, 3) == 0);
            new_setup(n[10:0]);
            ncols = $urandom_range(0, 9) == 0 ? $urandom_range(12, 14) : $urandom_range(1, 6);
            for (int c = 0; c < ncols; c++)
            begin
                r   = $urandom_range(0, 99);
                len = n;
                if (r < 8) len = $urandom_range(1, n + 3);
                if (r < 4 && heavy_ops < HEAVY_CAP)
                begin
                    column(FUNC_EXTRA, len, 0);
                end
                else if (r < 10)
                begin
                    column(FUNC_COLUMN, len, 30);
                end
                else
                begin
                    column(FUNC_COLUMN, len, 0);
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    send(func_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                         $urandom_range(0, 1));
                end
            end
            if (heavy_ops < HEAVY_CAP)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    column(FUNC_EXTRA, n, 0);
                end
                else
                begin
                    send(FUNC_QUERY, $urandom_range(0, 1), $urandom_range(0, 1));
                end
            end
        end
        no_idle = 0;
        settle();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
